[rtl/mudp64_pkg.sv]
// constants, codes and types shared by the moldudp64 packetizer
package mudp64_pkg;

  localparam int PAYLOAD_BYTES = 1024;
  localparam int HDR_BYTES     = 20;
  localparam int HDR_IDX_W     = 5;
  localparam logic [15:0] MAX_COUNT = 16'hFFFF;

  // widths of the payload bookkeeping
  localparam int FILL_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int POS_W  = $clog2(PAYLOAD_BYTES);
  localparam int RPTR_W = $clog2(PAYLOAD_BYTES + HDR_BYTES);
  localparam int NEED_W = 18;

  // payload store: two banks of four byte lanes each
  localparam int BANKS      = 2;
  localparam int LANES      = 4;
  localparam int LANE_SEL_W = 2;
  localparam int LANE_AW    = POS_W - LANE_SEL_W;
  localparam int LANE_DEPTH = (PAYLOAD_BYTES + LANES - 1) / LANES;
  localparam int MEM_SEL_W  = 1 + LANE_SEL_W;

  // configuration port
  localparam int CFG_AW = 4;
  localparam logic REG_SESSION_HEAD = 1'b0;
  localparam logic REG_SESSION_TAIL = 1'b1;

  // item modes
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_FLUSH  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // one byte write into the payload store
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } wr_req_t;

endpackage

[rtl/moldudp64_packetizer_unit.sv]
// moldudp64 packetizer: message byte framing, two-bank payload store, datagram readout
//
// input beats (s_*) carry one item each: append a message byte, flush the open
// payload, or read the next byte of the sealed datagram. every input beat yields
// exactly one result beat (m_*) with a status, the datagram byte, a last flag
// and a flag that says the beat sealed a datagram.
// throughput is one beat per cycle, with no gaps for any mix of modes, while the
// receiver takes each result. the result of a beat is presented in the cycle after it
// is accepted, since the synchronous read of the payload store sits between the two.
// the result sits in an output register; while the receiver holds m_tready low
// and a result is waiting, s_tready drops, so the block stalls with it and
// nothing is lost. a new beat is taken in the same cycle the waiting one leaves.
// the payload store is eight byte-lane memories (two banks of four lanes); a
// message's length prefix and its last data byte land in the same beat, so the
// last data byte is held in a pending register and written in the cycle after.
// synchronous reset clears all bookkeeping; the payload store is not cleared and needs
// no clearing pass, so beats are taken from the first cycle after reset. the user is to
// write the session registers through the apb port only while idle; it is not enforced.
module moldudp64_packetizer_unit
  import mudp64_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // data_byte [7:0], msg_length [23:8]
  input  logic [2:0]        s_tuser,   // mode [1:0], first_of_message [2]
  input  logic              s_tlast,   // last_of_message
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // out_byte [7:0]
  output logic [2:0]        m_tuser,   // status [1:0], sealed [2]
  output logic              m_tlast,   // datagram_last
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  // session registers
  logic [63:0] session_head;
  logic [15:0] session_tail;

  // payload bookkeeping
  logic [FILL_W-1:0] fill_length, fill_length_next;
  logic [15:0]       message_count, message_count_next;
  logic [63:0]       next_sequence, next_sequence_next;
  logic              active_bank, active_bank_next;
  logic              sealed_valid, sealed_valid_next;
  logic [63:0]       sealed_first_seq, sealed_first_seq_next;
  logic [15:0]       sealed_count, sealed_count_next;
  logic [FILL_W-1:0] sealed_length, sealed_length_next;
  logic [RPTR_W-1:0] read_pointer, read_pointer_next;
  logic              dropping, dropping_next;
  logic              msg_open, msg_open_next;
  logic [FILL_W-1:0] msg_declared, msg_declared_next;
  logic [FILL_W-1:0] msg_received, msg_received_next;

  // last data byte of a message, written in the cycle after it arrives
  logic              pend_valid, pend_valid_next;
  logic              pend_bank, pend_bank_next;
  logic [POS_W-1:0]  pend_pos, pend_pos_next;
  logic [7:0]        pend_byte, pend_byte_next;

  // result register
  logic                 out_valid;
  logic [1:0]           res_status, res_status_next;
  logic                 res_sealed, res_sealed_next;
  logic                 res_last, res_last_next;
  logic [7:0]           res_hdr_byte, res_hdr_byte_next;
  logic                 res_from_store, res_from_store_next;
  logic [MEM_SEL_W-1:0] res_sel, res_sel_next;

  // input fields
  logic        accept;
  logic [1:0]  in_mode;
  logic [7:0]  in_byte;
  logic [15:0] in_len;
  logic        in_first;

  // store access
  wr_req_t          req_pend, req_data, req_hi, req_lo;
  logic             rd_en;
  logic [POS_W-1:0] rd_pos;
  logic [7:0]       lane_rdata [BANKS*LANES];

  // datagram header, byte 0 in the top bits
  logic [HDR_BYTES*8-1:0] hdr_vec;
  logic [HDR_IDX_W-1:0]   hdr_idx;

  assign in_mode  = s_tuser[1:0];
  assign in_first = s_tuser[2];
  assign in_byte  = s_tdata[7:0];
  assign in_len   = s_tdata[23:8];

  // output register frees up when its beat leaves
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign hdr_vec = {session_head, session_tail, sealed_first_seq, sealed_count};
  assign hdr_idx = HDR_IDX_W'(HDR_BYTES - 1) - read_pointer[HDR_IDX_W-1:0];
  assign rd_pos  = POS_W'(read_pointer - RPTR_W'(HDR_BYTES));

  assign req_pend = '{en: pend_valid, bank: pend_bank, pos: pend_pos, data: pend_byte};

  // ---------------------------------------------------------------------------
  // item processing
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [NEED_W-1:0] need;
    logic              too_big;
    logic              must_seal;
    logic              do_seal;
    logic              do_body;
    logic [FILL_W-1:0] base_fill;
    logic              base_bank;
    logic [15:0]       base_count;
    logic [FILL_W-1:0] recv_cur;
    logic [FILL_W-1:0] decl_cur;
    logic              take;
    logic [FILL_W-1:0] recv_new;
    logic [15:0]       prefix;
    logic [POS_W-1:0]  data_pos;
    logic [POS_W-1:0]  msg_pos;
    logic [RPTR_W:0]   rptr_inc;
    logic [RPTR_W:0]   total;

    fill_length_next      = fill_length;
    message_count_next    = message_count;
    next_sequence_next    = next_sequence;
    active_bank_next      = active_bank;
    sealed_valid_next     = sealed_valid;
    sealed_first_seq_next = sealed_first_seq;
    sealed_count_next     = sealed_count;
    sealed_length_next    = sealed_length;
    read_pointer_next     = read_pointer;
    dropping_next         = dropping;
    msg_open_next         = msg_open;
    msg_declared_next     = msg_declared;
    msg_received_next     = msg_received;

    pend_valid_next = 1'b0;
    pend_bank_next  = pend_bank;
    pend_pos_next   = pend_pos;
    pend_byte_next  = pend_byte;

    res_status_next     = ST_OK;
    res_sealed_next     = 1'b0;
    res_last_next       = 1'b0;
    res_hdr_byte_next   = '0;
    res_from_store_next = 1'b0;
    res_sel_next        = {~active_bank, rd_pos[LANE_SEL_W-1:0]};

    req_data = '0;
    req_hi   = '0;
    req_lo   = '0;
    rd_en    = 1'b0;

    need      = NEED_W'(in_len) + NEED_W'(2);
    too_big   = need > NEED_W'(PAYLOAD_BYTES);
    // open payload cannot take this message
    must_seal = (message_count != '0) &&
                ((NEED_W'(fill_length) + need > NEED_W'(PAYLOAD_BYTES)) ||
                 (message_count == MAX_COUNT));
    do_seal   = 1'b0;
    do_body   = 1'b0;
    rptr_inc  = (RPTR_W+1)'(read_pointer) + (RPTR_W+1)'(1);
    total     = (RPTR_W+1)'(HDR_BYTES) + (RPTR_W+1)'(sealed_length);

    if (accept) begin
      case (in_mode)
        MODE_APPEND: begin
          if (in_first) begin
            if (too_big) begin
              res_status_next = ST_DROPPED;
              msg_open_next   = 1'b0;
              dropping_next   = !s_tlast;
            end else if (must_seal && sealed_valid) begin
              res_status_next = ST_BUSY;
            end else begin
              do_seal       = must_seal;
              dropping_next = 1'b0;
              do_body       = 1'b1;
            end
          end else if (dropping) begin
            if (s_tlast) begin
              dropping_next = 1'b0;
            end
            res_status_next = ST_DROPPED;
          end else if (msg_open) begin
            do_body = 1'b1;
          end
        end
        MODE_FLUSH: begin
          if (message_count != '0) begin
            if (sealed_valid) begin
              res_status_next = ST_BUSY;
            end else begin
              do_seal       = 1'b1;
              msg_open_next = 1'b0;
            end
          end
        end
        MODE_READ: begin
          if (!sealed_valid) begin
            res_status_next = ST_EMPTY;
          end else begin
            if (read_pointer < RPTR_W'(HDR_BYTES)) begin
              res_hdr_byte_next = hdr_vec[{hdr_idx, 3'b000} +: 8];
            end else begin
              res_from_store_next = 1'b1;
              rd_en               = 1'b1;
            end
            if (rptr_inc >= total) begin
              res_last_next     = 1'b1;
              sealed_valid_next = 1'b0;
              read_pointer_next = '0;
            end else begin
              read_pointer_next = RPTR_W'(rptr_inc);
            end
          end
        end
        default: ;
      endcase
    end

    // seal: swap banks and latch the header of the finished payload
    if (do_seal) begin
      res_sealed_next       = 1'b1;
      sealed_valid_next     = 1'b1;
      sealed_first_seq_next = next_sequence - 64'(message_count);
      sealed_count_next     = message_count;
      sealed_length_next    = fill_length;
      read_pointer_next     = '0;
      active_bank_next      = ~active_bank;
      fill_length_next      = '0;
      message_count_next    = '0;
    end

    base_fill  = do_seal ? '0 : fill_length;
    base_bank  = active_bank ^ do_seal;
    base_count = do_seal ? '0 : message_count;
    recv_cur   = in_first ? '0 : msg_received;
    decl_cur   = in_first ? FILL_W'(in_len) : msg_declared;
    take       = recv_cur < decl_cur;
    recv_new   = recv_cur + FILL_W'(take);
    prefix     = 16'(recv_new);
    msg_pos    = POS_W'(base_fill);
    data_pos   = POS_W'(base_fill + recv_cur + FILL_W'(2));

    // message byte: bytes past the declared length are ignored
    if (do_body) begin
      msg_open_next     = 1'b1;
      msg_declared_next = decl_cur;
      msg_received_next = recv_new;
      if (take && !s_tlast) begin
        req_data = '{en: 1'b1, bank: base_bank, pos: data_pos, data: in_byte};
      end
      if (s_tlast) begin
        // the final data byte goes out next cycle, the prefix lanes are busy now
        if (take) begin
          pend_valid_next = 1'b1;
          pend_bank_next  = base_bank;
          pend_pos_next   = data_pos;
          pend_byte_next  = in_byte;
        end
        req_hi = '{en: 1'b1, bank: base_bank, pos: msg_pos, data: prefix[15:8]};
        req_lo = '{en: 1'b1, bank: base_bank, pos: msg_pos + POS_W'(1), data: prefix[7:0]};
        fill_length_next   = base_fill + FILL_W'(2) + recv_new;
        message_count_next = base_count + 16'd1;
        next_sequence_next = next_sequence + 64'd1;
        msg_open_next      = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload store: one memory per bank and byte lane
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < BANKS * LANES; g++) begin : g_lane
    logic               we;
    logic [LANE_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [7:0]         rd_q;
    logic [7:0]         lane_mem [LANE_DEPTH];

    // writes of one cycle never share a lane, so the pick order is free
    always_comb begin
      wr_req_t reqs [4];
      reqs[0] = req_pend;
      reqs[1] = req_data;
      reqs[2] = req_hi;
      reqs[3] = req_lo;
      we    = 1'b0;
      waddr = '0;
      wdata = '0;
      for (int r = 0; r < 4; r++) begin
        if (reqs[r].en && reqs[r].bank == 1'(g / LANES) &&
            reqs[r].pos[LANE_SEL_W-1:0] == LANE_SEL_W'(g % LANES)) begin
          we    = 1'b1;
          waddr = reqs[r].pos[POS_W-1:LANE_SEL_W];
          wdata = reqs[r].data;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (we) begin
        lane_mem[waddr] <= wdata;
      end
      if (rd_en) begin
        rd_q <= lane_mem[rd_pos[POS_W-1:LANE_SEL_W]];
      end
    end

    assign lane_rdata[g] = rd_q;
  end

  // ---------------------------------------------------------------------------
  // state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_length      <= '0;
      message_count    <= '0;
      next_sequence    <= 64'd1;
      active_bank      <= 1'b0;
      sealed_valid     <= 1'b0;
      sealed_first_seq <= '0;
      sealed_count     <= '0;
      sealed_length    <= '0;
      read_pointer     <= '0;
      dropping         <= 1'b0;
      msg_open         <= 1'b0;
      msg_declared     <= '0;
      msg_received     <= '0;
      pend_valid       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      fill_length      <= fill_length_next;
      message_count    <= message_count_next;
      next_sequence    <= next_sequence_next;
      active_bank      <= active_bank_next;
      sealed_valid     <= sealed_valid_next;
      sealed_first_seq <= sealed_first_seq_next;
      sealed_count     <= sealed_count_next;
      sealed_length    <= sealed_length_next;
      read_pointer     <= read_pointer_next;
      dropping         <= dropping_next;
      msg_open         <= msg_open_next;
      msg_declared     <= msg_declared_next;
      msg_received     <= msg_received_next;
      pend_valid       <= pend_valid_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pending write payload and result payload
  always_ff @(posedge clk) begin
    pend_bank <= pend_bank_next;
    pend_pos  <= pend_pos_next;
    pend_byte <= pend_byte_next;
    if (accept) begin
      res_status     <= res_status_next;
      res_sealed     <= res_sealed_next;
      res_last       <= res_last_next;
      res_hdr_byte   <= res_hdr_byte_next;
      res_from_store <= res_from_store_next;
      res_sel        <= res_sel_next;
    end
  end

  // result beat
  assign m_tvalid = out_valid;
  assign m_tdata  = res_from_store ? lane_rdata[res_sel] : res_hdr_byte;
  assign m_tuser  = {res_sealed, res_status};
  assign m_tlast  = res_last;

  // ---------------------------------------------------------------------------
  // configuration port, registers at byte offsets 0 and 8
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_SESSION_TAIL) ? 64'(session_tail) : session_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      session_head <= '0;
      session_tail <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3])
        REG_SESSION_HEAD: session_head <= pwdata;
        REG_SESSION_TAIL: session_tail <= pwdata[15:0];
        default: ;
      endcase
    end
  end

endmodule
